### sv/terminal_key_decoder_defines.svh
// ----------------------------------------------------------------------------
// terminal_key_decoder_defines
// Assertion macros used by the terminal key decoder core (tkd_core).
// ----------------------------------------------------------------------------
`ifndef TERMINAL_KEY_DECODER_DEFINES_SVH
`define TERMINAL_KEY_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TKD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tkd: same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define TKD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tkd: next-cycle implication violated");

`endif

### sv/tkd_pkg.sv
// ----------------------------------------------------------------------------
// tkd_pkg
// Item types and codes of the terminal key decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tkd_pkg;

   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_TIMEOUT = 2'd1;
   localparam logic [1:0] KIND_EOF     = 2'd2;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   localparam logic [4:0] KEY_NONE      = 5'd0;
   localparam logic [4:0] KEY_ESCAPE    = 5'd1;
   localparam logic [4:0] KEY_UP        = 5'd2;
   localparam logic [4:0] KEY_DOWN      = 5'd3;
   localparam logic [4:0] KEY_RIGHT     = 5'd4;
   localparam logic [4:0] KEY_LEFT      = 5'd5;
   localparam logic [4:0] KEY_HOME      = 5'd6;
   localparam logic [4:0] KEY_END       = 5'd7;
   localparam logic [4:0] KEY_DELETE    = 5'd8;
   localparam logic [4:0] KEY_PGUP      = 5'd9;
   localparam logic [4:0] KEY_PGDN      = 5'd10;
   localparam logic [4:0] KEY_EOF       = 5'd11;
   localparam logic [4:0] KEY_ENTER     = 5'd12;
   localparam logic [4:0] KEY_TAB       = 5'd13;
   localparam logic [4:0] KEY_BACKSPACE = 5'd14;
   localparam logic [4:0] KEY_CTRL      = 5'd15;
   localparam logic [4:0] KEY_CHAR      = 5'd16;

   localparam logic [7:0] BYTE_ESC = 8'h1b;
   localparam logic [7:0] BYTE_DEL = 8'd127;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_HIGH = 8'h80;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [4:0]  key_kind;
      logic [7:0]  key_char;
      logic [31:0] text_bytes;
      logic [2:0]  text_length;
   } rsp_item_type;

   function automatic logic [4:0] final_letter_key(input logic [7:0] b);
      logic [4:0] k;
      k = KEY_NONE;
      unique case (b)
         "A": k = KEY_UP;
         "B": k = KEY_DOWN;
         "C": k = KEY_RIGHT;
         "D": k = KEY_LEFT;
         "H": k = KEY_HOME;
         "F": k = KEY_END;
         default: k = KEY_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] digit_key(input logic [7:0] d);
      logic [4:0] k;
      k = KEY_NONE;
      unique case (d)
         "1", "7": k = KEY_HOME;
         "4", "8": k = KEY_END;
         "3":      k = KEY_DELETE;
         "5":      k = KEY_PGUP;
         "6":      k = KEY_PGDN;
         default:  k = KEY_NONE;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

### sv/tkd_core.sv
// ----------------------------------------------------------------------------
// tkd_core
// Decoder state machine: holds the sequence state and turns one item into
// at most one key event.
// ----------------------------------------------------------------------------
`default_nettype none
`include "terminal_key_decoder_defines.svh"

module tkd_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step_en,
   input  wire tkd_pkg::req_item_type item,
   output logic                       emit,
   output tkd_pkg::rsp_item_type      result
);
   import tkd_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_ESC     = 3'd1,
      MODE_BRACKET = 3'd2,
      MODE_DIGIT   = 3'd3,
      MODE_UTF8    = 3'd4
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [7:0]  pending_digit_ff, pending_digit_in;
   logic [31:0] text_store_ff, text_store_in;
   logic [2:0]  text_count_ff, text_count_in;
   logic [1:0]  bytes_left_ff, bytes_left_in;

   always_comb begin
      logic [7:0]  b;
      logic [1:0]  extra;
      logic [31:0] store;
      logic [2:0]  count;
      logic [1:0]  left;
      logic        send_text;
      logic [4:0]  k;

      b = item.data_byte;
      extra = 2'd0;
      store = text_store_ff;
      count = text_count_ff;
      left = bytes_left_ff;
      send_text = 1'b0;
      k = KEY_NONE;

      mode_in = mode_ff;
      pending_digit_in = pending_digit_ff;
      text_store_in = text_store_ff;
      text_count_in = text_count_ff;
      bytes_left_in = bytes_left_ff;
      emit = 1'b0;
      result = '0;

      if (step_en && item.kind != KIND_UNUSED) begin
         unique case (mode_ff)
            MODE_IDLE: begin
               if (item.kind == KIND_BYTE) begin
                  priority if (b == BYTE_ESC) begin
                     mode_in = MODE_ESC;
                  end else if (b == 8'd13 || b == 8'd10) begin
                     emit = 1'b1;
                     result.key_kind = KEY_ENTER;
                  end else if (b == 8'd9) begin
                     emit = 1'b1;
                     result.key_kind = KEY_TAB;
                  end else if (b == BYTE_DEL || b == 8'd8) begin
                     emit = 1'b1;
                     result.key_kind = KEY_BACKSPACE;
                  end else if (b < BYTE_SPACE) begin
                     emit = 1'b1;
                     result.key_kind = KEY_CTRL;
                     result.key_char = b + 8'h60;
                  end else begin
                     if (b >= BYTE_HIGH) begin
                        priority if ((b & 8'he0) == 8'hc0) begin
                           extra = 2'd1;
                        end else if ((b & 8'hf0) == 8'he0) begin
                           extra = 2'd2;
                        end else if ((b & 8'hf8) == 8'hf0) begin
                           extra = 2'd3;
                        end else begin
                           extra = 2'd0;
                        end
                     end
                     store = {24'd0, b};
                     count = 3'd1;
                     if (extra == 2'd0) begin
                        send_text = 1'b1;
                     end else begin
                        text_store_in = store;
                        text_count_in = count;
                        bytes_left_in = extra;
                        mode_in = MODE_UTF8;
                     end
                  end
               end else if (item.kind == KIND_EOF) begin
                  emit = 1'b1;
                  result.key_kind = KEY_EOF;
               end
            end
            MODE_UTF8: begin
               if (item.kind != KIND_BYTE) begin
                  send_text = 1'b1;
               end else begin
                  if (count < 3'd4) begin
                     store = store | ({24'd0, b} << {count[1:0], 3'b000});
                     count = count + 3'd1;
                  end
                  left = left - 2'd1;
                  if (left == 2'd0) begin
                     send_text = 1'b1;
                  end else begin
                     text_store_in = store;
                     text_count_in = count;
                     bytes_left_in = left;
                  end
               end
            end
            MODE_ESC: begin
               mode_in = MODE_IDLE;
               if (item.kind != KIND_BYTE) begin
                  emit = 1'b1;
                  result.key_kind = KEY_ESCAPE;
               end else if (b == "[" || b == "O") begin
                  mode_in = MODE_BRACKET;
               end else begin
                  emit = 1'b1;
               end
            end
            MODE_BRACKET: begin
               mode_in = MODE_IDLE;
               k = final_letter_key(b);
               if (item.kind != KIND_BYTE) begin
                  emit = 1'b1;
               end else if (k != KEY_NONE) begin
                  emit = 1'b1;
                  result.key_kind = k;
               end else if (b >= "0" && b <= "9") begin
                  pending_digit_in = b;
                  mode_in = MODE_DIGIT;
               end else begin
                  emit = 1'b1;
               end
            end
            MODE_DIGIT: begin
               mode_in = MODE_IDLE;
               pending_digit_in = 8'd0;
               emit = 1'b1;
               if (item.kind == KIND_BYTE && b == "~") begin
                  result.key_kind = digit_key(pending_digit_ff);
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase

         if (send_text) begin
            emit = 1'b1;
            result.key_kind = KEY_CHAR;
            result.key_char = store[7:0];
            result.text_bytes = store;
            result.text_length = count;
            mode_in = MODE_IDLE;
            text_store_in = 32'd0;
            text_count_in = 3'd0;
            bytes_left_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pending_digit_ff <= 8'd0;
         text_store_ff <= 32'd0;
         text_count_ff <= 3'd0;
         bytes_left_ff <= 2'd0;
      end else begin
         mode_ff <= mode_in;
         pending_digit_ff <= pending_digit_in;
         text_store_ff <= text_store_in;
         text_count_ff <= text_count_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   `TKD_ASSERT_IMPLY(a_idle_text_clear, clock, reset, mode_ff != MODE_UTF8, text_count_ff == 3'd0 && bytes_left_ff == 2'd0)
   `TKD_ASSERT_IMPLY(a_utf8_fill, clock, reset, mode_ff == MODE_UTF8, bytes_left_ff != 2'd0 && text_count_ff != 3'd0 && text_count_ff + 3'(bytes_left_ff) <= 3'd4)
   `TKD_ASSERT_IMPLY(a_char_length, clock, reset, emit && result.key_kind == KEY_CHAR, result.text_length != 3'd0 && result.text_length <= 3'd4)
   `TKD_ASSERT_NEXT(a_step_holds_state, clock, reset, !step_en, $stable(mode_ff) && $stable(text_store_ff))

endmodule

`default_nettype wire

### sv/terminal_key_decoder.sv
// ----------------------------------------------------------------------------
// terminal_key_decoder: raw terminal byte stream to key events.
// Each accepted item is registered in in_item_ff; its key event, if any, in rsp_item_ff.
// Throughput: one item per cycle; a result held by rsp_ready stalls the input.
// Reset: synchronous; returns to idle with empty UTF-8 collection.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_key_decoder (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire tkd_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output tkd_pkg::rsp_item_type      rsp_item
);
   import tkd_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   logic         advance;
   logic         core_emit;
   rsp_item_type core_result;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   tkd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step_en(advance),
      .item   (in_item_ff),
      .emit   (core_emit),
      .result (core_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = core_emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
      if (advance && core_emit) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

endmodule

`default_nettype wire
